// ----- design/sfr_pkg.sv -----
// Shared constants and types for the SBUS frame receiver.
`timescale 1ns / 1ps
package sfr_pkg;

    localparam int FRAME_BYTES    = 25;
    localparam int CHANNEL_COUNT  = 16;
    localparam int CH_BITS        = 11;
    localparam int DATA_BYTES     = 22;
    localparam int CHAN_DATA_BITS = CHANNEL_COUNT * CH_BITS;
    localparam int IDX_BITS       = 5;
    localparam int CH_IDX_BITS    = 4;
    localparam int CFG_ADDR_BITS  = 2;
    localparam int CFG_DATA_BITS  = 24;
    localparam int OUT_DATA_BITS  = 24;

    localparam logic [CH_IDX_BITS-1:0] LAST_CHANNEL = CH_IDX_BITS'(CHANNEL_COUNT - 1);
    localparam logic [IDX_BITS-1:0]    LAST_BYTE    = IDX_BITS'(FRAME_BYTES - 1);
    localparam logic [IDX_BITS-1:0]    FULL_INDEX   = IDX_BITS'(FRAME_BYTES);

    typedef enum logic [CFG_ADDR_BITS-1:0] {
        CFG_HEADER  = 2'd0,
        CFG_FOOTER  = 2'd1,
        CFG_GAP     = 2'd2,
        CFG_TIMEOUT = 2'd3
    } t_cfg_reg;

    // One tick's outcome, waiting to be sent as one status result or a channel burst.
    typedef struct packed {
        logic                      is_frame;
        logic [3:0]                flags;
        logic                      link_ok;
        logic [CHAN_DATA_BITS-1:0] chan_data;
    } t_slot;

endpackage

// ----- design/sbus_frame_receiver.sv -----
// Top level of the SBUS frame receiver: tick processing, frame check and result burst.
//
//  Channel   Direction  Handshake                     Content
//  s_axis    in         tvalid/tready                 one tick: tuser byte_valid, tdata rx_byte
//  m_axis    out        tvalid/tready                 one result: channel, flags, link, tlast
//  cfg       in         i_cfg_we                      register write, index i_cfg_addr
//
// A tick is processed in the cycle it is taken; its first result is registered into an
// output slot. Ticks without an accepted frame give one result each and stream at one
// per cycle unless the output stalls. An accepted frame gives 16 results from the output
// slot; one more tick is held in a second slot meanwhile. Reset (synchronous, active low)
// clears counters, flags and both slots and loads default configuration. A stall on the
// output holds the shown result and, once the second slot is full, stalls the input.
`timescale 1ns / 1ps
module sbus_frame_receiver (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // bit 0: byte_valid
    input  logic                                s_axis_tuser,
    // bits 7:0: rx_byte
    input  logic [7:0]                          s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // bit 0: channel_valid
    output logic                                m_axis_tuser,
    // bits 3:0 channel_index, 14:4 channel_value, 15 failsafe, 16 frame_lost,
    // 17 digital_ch17, 18 digital_ch18, 19 link_ok, 23:20 zero
    output logic [sfr_pkg::OUT_DATA_BITS-1:0]   m_axis_tdata,
    output logic                                m_axis_tlast,
    input  logic                                i_cfg_we,
    input  logic [sfr_pkg::CFG_ADDR_BITS-1:0]   i_cfg_addr,
    input  logic [sfr_pkg::CFG_DATA_BITS-1:0]   i_cfg_data
);
    import sfr_pkg::*;

    logic [7:0]             r_header;
    logic [7:0]             r_footer;
    logic [15:0]            r_gap;
    logic [23:0]            r_timeout;

    logic [7:0]             r_buf [FRAME_BYTES];
    logic [IDX_BITS-1:0]    r_idx;
    logic [15:0]            r_tsb;
    logic [23:0]            r_tsv;
    logic                   r_timed_out;
    logic [3:0]             r_flags;

    logic                   r_a_valid;
    t_slot                  r_a;
    logic [CH_IDX_BITS-1:0] r_a_idx;
    logic                   r_b_valid;
    t_slot                  r_b;

    logic                   accept;
    logic [15:0]            tsb_inc;
    logic [23:0]            tsv_inc;
    logic [IDX_BITS-1:0]    idx_eff;
    logic                   do_write;
    logic                   frame_ok;
    logic [IDX_BITS-1:0]    n_idx;
    logic [15:0]            n_tsb;
    logic [23:0]            n_tsv;
    logic                   n_timed_out;
    logic [3:0]             n_flags;
    logic [CHAN_DATA_BITS-1:0] chan_bits;
    t_slot                  new_slot;
    logic                   a_done;
    logic                   a_free;
    logic [CH_BITS-1:0]     chan_value;

    assign accept = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = !r_b_valid;

    always_comb begin
        tsb_inc = (r_tsb == 16'hFFFF) ? r_tsb : r_tsb + 16'd1;
        tsv_inc = (r_tsv == 24'hFFFFFF) ? r_tsv : r_tsv + 24'd1;
        idx_eff = (tsb_inc > r_gap) ? '0 : r_idx;
        do_write = s_axis_tuser && (idx_eff < FULL_INDEX);
        frame_ok = do_write && (idx_eff == LAST_BYTE) && (r_buf[0] == r_header)
                   && (s_axis_tdata == r_footer);
        n_tsb = tsb_inc;
        n_idx = r_idx;
        if (s_axis_tuser) begin
            n_tsb = '0;
            n_idx = idx_eff;
            if (do_write) begin
                if ((idx_eff == LAST_BYTE) && !frame_ok) begin
                    n_idx = '0;
                end else begin
                    n_idx = idx_eff + IDX_BITS'(1);
                end
            end
        end
        n_tsv   = frame_ok ? '0 : tsv_inc;
        n_flags = frame_ok ? r_buf[23][3:0] : r_flags;
        n_timed_out = (frame_ok ? 1'b0 : r_timed_out) || (n_tsv > r_timeout);
        for (int k = 0; k < DATA_BYTES; k++) begin
            chan_bits[8*k +: 8] = r_buf[k+1];
        end
        new_slot.is_frame  = frame_ok;
        new_slot.flags     = n_flags;
        new_slot.link_ok   = !n_timed_out;
        new_slot.chan_data = chan_bits;
    end

    assign a_done = r_a_valid && m_axis_tready && (!r_a.is_frame || (r_a_idx == LAST_CHANNEL));
    assign a_free = !r_a_valid || a_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header    <= 8'd15;
            r_footer    <= 8'd0;
            r_gap       <= 16'd3000;
            r_timeout   <= 24'd100000;
            r_idx       <= '0;
            r_tsb       <= '0;
            r_tsv       <= '0;
            r_timed_out <= 1'b0;
            r_flags     <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (t_cfg_reg'(i_cfg_addr))
                    CFG_HEADER:  r_header  <= i_cfg_data[7:0];
                    CFG_FOOTER:  r_footer  <= i_cfg_data[7:0];
                    CFG_GAP:     r_gap     <= i_cfg_data[15:0];
                    CFG_TIMEOUT: r_timeout <= i_cfg_data[23:0];
                endcase
            end
            if (accept) begin
                r_idx       <= n_idx;
                r_tsb       <= n_tsb;
                r_tsv       <= n_tsv;
                r_timed_out <= n_timed_out;
                r_flags     <= n_flags;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && do_write) begin
            r_buf[idx_eff] <= s_axis_tdata;
        end
    end

    // Slot A drives the output; slot B holds one tick while A is busy.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_a_idx   <= '0;
        end else begin
            if (r_a_valid && r_a.is_frame && m_axis_tready && !a_done) begin
                r_a_idx <= r_a_idx + CH_IDX_BITS'(1);
            end
            if (r_b_valid) begin
                if (a_free) begin
                    r_a_valid <= 1'b1;
                    r_a       <= r_b;
                    r_a_idx   <= '0;
                    r_b_valid <= 1'b0;
                end
            end else if (accept) begin
                if (a_free) begin
                    r_a_valid <= 1'b1;
                    r_a       <= new_slot;
                    r_a_idx   <= '0;
                end else begin
                    r_b_valid <= 1'b1;
                    r_b       <= new_slot;
                end
            end else if (a_done) begin
                r_a_valid <= 1'b0;
            end
        end
    end

    assign chan_value = r_a.chan_data[CH_BITS*r_a_idx +: CH_BITS];

    always_comb begin
        m_axis_tvalid = r_a_valid;
        m_axis_tuser  = r_a.is_frame;
        m_axis_tlast  = !r_a.is_frame || (r_a_idx == LAST_CHANNEL);
        m_axis_tdata  = '0;
        m_axis_tdata[3:0]  = r_a.is_frame ? r_a_idx : '0;
        m_axis_tdata[14:4] = r_a.is_frame ? chan_value : '0;
        m_axis_tdata[15]   = r_a.flags[3];
        m_axis_tdata[16]   = r_a.flags[2];
        m_axis_tdata[17]   = r_a.flags[0];
        m_axis_tdata[18]   = r_a.flags[1];
        m_axis_tdata[19]   = r_a.link_ok;
    end

endmodule

// ----- design/sfr_checker.sv -----
// Port-level assertions for the SBUS frame receiver and their bind.
`timescale 1ns / 1ps
module sfr_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic                              m_axis_tuser,
    input logic [sfr_pkg::OUT_DATA_BITS-1:0] m_axis_tdata,
    input logic                              m_axis_tlast
);
    import sfr_pkg::*;

    // A status result always stands alone.
    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> m_axis_tlast)
        else $error("status result without tlast");

    // A channel burst ends exactly on the last channel.
    a_burst_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tlast == (m_axis_tdata[3:0] == LAST_CHANNEL)))
        else $error("burst tlast does not match the last channel");

    // Channels of a burst follow each other without a gap.
    a_burst_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && m_axis_tuser && !m_axis_tlast) |=>
        (m_axis_tvalid && m_axis_tuser && (m_axis_tdata[3:0] == $past(m_axis_tdata[3:0]) + 4'd1)))
        else $error("channel burst broken or out of order");

    // A frame that was just accepted always reports the link as good.
    a_frame_link: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> m_axis_tdata[19])
        else $error("accepted frame reports timed-out link");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result changed");

endmodule

bind sbus_frame_receiver sfr_checker u_sfr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

// ----- tb/tb_sbus_frame_receiver.sv -----
// Self-checking testbench for the SBUS frame receiver: directed frame cases under varied idling.
`timescale 1ns / 1ps
module tb_sbus_frame_receiver;
    import sfr_pkg::*;

    localparam int CLK_HALF       = 10;
    localparam int RESET_CYCLES   = 6;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 4;
    localparam int END_CYCLES     = 20;

    typedef logic [FRAME_BYTES-1:0][7:0] t_frame;

    typedef struct packed {
        logic                   chan_valid;
        logic [CH_IDX_BITS-1:0] chan_index;
        logic [CH_BITS-1:0]     chan_value;
        logic                   failsafe;
        logic                   frame_lost;
        logic                   ch17;
        logic                   ch18;
        logic                   link_ok;
        logic                   last_flag;
    } t_rc_result;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     s_axis_tvalid = 1'b0;
    logic                     s_axis_tready;
    logic                     s_axis_tuser = 1'b0;
    logic [7:0]               s_axis_tdata = 8'h00;
    logic                     m_axis_tvalid;
    logic                     m_axis_tready = 1'b0;
    logic                     m_axis_tuser;
    logic [OUT_DATA_BITS-1:0] m_axis_tdata;
    logic                     m_axis_tlast;
    logic                     i_cfg_we = 1'b0;
    logic [CFG_ADDR_BITS-1:0] i_cfg_addr = '0;
    logic [CFG_DATA_BITS-1:0] i_cfg_data = '0;

    // Shadow of the receiver state.
    logic [7:0]  hdr_cfg = 8'd15;
    logic [7:0]  ftr_cfg = 8'd0;
    logic [15:0] gap_cfg = 16'd3000;
    logic [23:0] timeout_cfg = 24'd100000;
    logic [7:0]  rx_buf [FRAME_BYTES];
    logic [4:0]  wr_idx = '0;
    logic [15:0] since_byte = '0;
    logic [23:0] since_valid = '0;
    logic        link_lost = 1'b0;
    logic [3:0]  flag_bits = '0;

    t_rc_result  decoded_q [$];
    t_rc_result  want;
    int unsigned error_count = 0;
    int unsigned stall_cycles = 0;
    int unsigned send_idle_pct = 12;
    int unsigned recv_stall_pct = 64;

    sbus_frame_receiver dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic decode_tick(input logic bv, input logic [7:0] rx);
        logic                      accepted;
        logic [CHAN_DATA_BITS-1:0] payload;
        t_rc_result                res;
        accepted = 1'b0;
        if (since_byte != 16'hFFFF) since_byte++;
        if (since_valid != 24'hFFFFFF) since_valid++;
        if (bv) begin
            if (since_byte > gap_cfg) wr_idx = '0;
            since_byte = '0;
            if (wr_idx < FULL_INDEX) begin
                rx_buf[wr_idx] = rx;
                wr_idx++;
                if (wr_idx == FULL_INDEX) begin
                    if (rx_buf[0] == hdr_cfg && rx_buf[LAST_BYTE] == ftr_cfg) begin
                        accepted = 1'b1;
                        flag_bits = rx_buf[FRAME_BYTES-2][3:0];
                        since_valid = '0;
                        link_lost = 1'b0;
                    end else begin
                        wr_idx = '0;
                    end
                end
            end
        end
        if (since_valid > timeout_cfg) link_lost = 1'b1;

        for (int i = 0; i < DATA_BYTES; i++) payload[8*i +: 8] = rx_buf[i+1];
        res = '0;
        res.failsafe   = flag_bits[3];
        res.frame_lost = flag_bits[2];
        res.ch17       = flag_bits[0];
        res.ch18       = flag_bits[1];
        res.link_ok    = ~link_lost;
        if (!accepted) begin
            res.last_flag = 1'b1;
            decoded_q.push_back(res);
        end else begin
            for (int k = 0; k < CHANNEL_COUNT; k++) begin
                res.chan_valid = 1'b1;
                res.chan_index = CH_IDX_BITS'(k);
                res.chan_value = payload[CH_BITS*k +: CH_BITS];
                res.last_flag  = (res.chan_index == LAST_CHANNEL);
                decoded_q.push_back(res);
            end
        end
    endtask

    task automatic check_field(input string name, input int unsigned want_v,
                               input int unsigned got_v);
        if (want_v != got_v) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want_v, got_v);
            error_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (decoded_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual tuser %b tdata %h",
                         $time, m_axis_tuser, m_axis_tdata);
                error_count++;
            end else begin
                want = decoded_q.pop_front();
                check_field("channel_valid", want.chan_valid, m_axis_tuser);
                check_field("channel_index", want.chan_index, m_axis_tdata[3:0]);
                check_field("channel_value", want.chan_value, m_axis_tdata[14:4]);
                check_field("failsafe", want.failsafe, m_axis_tdata[15]);
                check_field("frame_lost", want.frame_lost, m_axis_tdata[16]);
                check_field("digital_ch17", want.ch17, m_axis_tdata[17]);
                check_field("digital_ch18", want.ch18, m_axis_tdata[18]);
                check_field("link_ok", want.link_ok, m_axis_tdata[19]);
                check_field("last", want.last_flag, m_axis_tlast);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    task automatic send_tick(input logic bv, input logic [7:0] rx);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= bv;
        s_axis_tdata  <= rx;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        decode_tick(bv, rx);
        if ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    task automatic send_idle(input int unsigned n);
        repeat (n) send_tick(1'b0, 8'($urandom_range(255)));
    endtask

    // Sends the first byte_count bytes; pause_ticks idle ticks go in before byte split_at.
    task automatic send_frame(input t_frame f, input int byte_count, input int split_at,
                              input int unsigned pause_ticks);
        for (int i = 0; i < byte_count; i++) begin
            if (i == split_at && pause_ticks > 0) send_idle(pause_ticks);
            send_tick(1'b1, f[i]);
        end
    endtask

    function automatic t_frame make_frame(input logic [7:0] head, input logic [7:0] foot,
                                          input logic [7:0] fill, input logic [7:0] flag_byte);
        t_frame f;
        for (int i = 1; i <= DATA_BYTES; i++) f[i] = fill;
        f[0]             = head;
        f[FRAME_BYTES-2] = flag_byte;
        f[FRAME_BYTES-1] = foot;
        return f;
    endfunction

    function automatic t_frame random_frame(input logic [7:0] head, input logic [7:0] foot);
        t_frame f;
        f = make_frame(head, foot, 8'h00, 8'($urandom_range(255)));
        for (int i = 1; i <= DATA_BYTES; i++) f[i] = 8'($urandom_range(255));
        return f;
    endfunction

    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (decoded_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_reg sel, input logic [CFG_DATA_BITS-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= sel;
        i_cfg_data <= val;
        @(posedge i_clk);
        case (sel)
            CFG_HEADER:  hdr_cfg = val[7:0];
            CFG_FOOTER:  ftr_cfg = val[7:0];
            CFG_GAP:     gap_cfg = val[15:0];
            CFG_TIMEOUT: timeout_cfg = val;
            default: ;
        endcase
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic test_reset_values();
        send_frame(random_frame(8'd15, 8'd0), FRAME_BYTES, 0, 0);
        send_idle(2);
    endtask

    task automatic test_channel_extremes();
        settle();
        write_reg(CFG_HEADER, 24'h00);
        write_reg(CFG_FOOTER, 24'hFF);
        write_reg(CFG_GAP, 24'd2);
        write_reg(CFG_TIMEOUT, 24'd1000);
        send_idle(2);
        send_frame(make_frame(8'h00, 8'hFF, 8'hFF, 8'hFF), FRAME_BYTES, 0, 0);
        // Without a gap the following bytes are ignored.
        send_frame(make_frame(8'h00, 8'hFF, 8'hAA, 8'h0A), 4, 0, 0);
    endtask

    task automatic test_bad_frames();
        frame_t_unused_guard();
    endtask

    task automatic frame_t_unused_guard();
        settle();
        write_reg(CFG_HEADER, 24'hFF);
        write_reg(CFG_FOOTER, 24'h00);
        send_idle(2);
        send_frame(random_frame(8'hFF, 8'h01), FRAME_BYTES, 0, 0);
        // A pause one tick short of the gap keeps the frame together.
        send_frame(random_frame(8'hFF, 8'h00), FRAME_BYTES, 10, 1);
    endtask

    task automatic test_zero_gap();
        settle();
        write_reg(CFG_GAP, 24'd0);
        send_frame(random_frame(hdr_cfg, ftr_cfg), 5, 0, 0);
        settle();
        write_reg(CFG_GAP, 24'd2);
    endtask

    task automatic test_link_timeout();
        settle();
        write_reg(CFG_TIMEOUT, 24'd0);
        send_idle(2);
        settle();
        write_reg(CFG_TIMEOUT, 24'd3);
        send_idle(2);
        send_frame(random_frame(hdr_cfg, ftr_cfg), FRAME_BYTES, 0, 0);
        send_idle(5);
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct  = 12;
        recv_stall_pct = 64;
        test_reset_values();
        test_channel_extremes();

        send_idle_pct  = 64;
        recv_stall_pct = 12;
        test_bad_frames();

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        test_zero_gap();
        test_link_timeout();

        settle();
        repeat (END_CYCLES) @(posedge i_clk);
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
